// File: rtl/core/mbc_pkg.sv
// Package for the matrix basis change block: command codes, register indexes
// and the control word passed from the sequencer to the datapath. No dependencies.
package mbc_pkg;
   localparam logic [1:0] CMD_LOAD_M  = 2'd0;
   localparam logic [1:0] CMD_LOAD_V  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   localparam logic [1:0] REG_SIZE = 2'd0;
   localparam logic [1:0] REG_DIR  = 2'd1;

   typedef struct packed {
      logic       load_m;
      logic       load_v;
      logic       clr_acc;
      logic       mac_en;
      logic       phase;
      logic       wr_pp;
      logic       wr_res;
      logic [2:0] i;
      logic [2:0] j;
      logic [2:0] k;
   } ctl_type;
endpackage

// File: rtl/core/mbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/core/mbc_datapath.sv
// Datapath: element stores, one multiply-accumulate unit, rounding and the
// combinational result. Depends on mbc_pkg and mbc_ram.
module mbc_datapath
   import mbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        direction,
   input  ctl_type     ctl,
   input  logic [2:0]  ld_row,
   input  logic [2:0]  ld_col,
   input  logic [31:0] ld_value,
   output logic [31:0] res_value
);
   logic [5:0]  m_wa, m_ra, v_ra, p_ra, p_wa;
   logic [31:0] m_wd, m_rd, v_rd, p_rd, a_op, b_op, rnd;
   logic        m_we;
   logic        tr;
   logic [2:0]  vr, vc;
   logic [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic        mac_d1_ff, mac_d2_ff, clr_d1_ff, clr_d2_ff;

   // Operand addresses: phase 0 reads A[i][k] and M[k][j];
   // phase 1 reads T[i][k] and B[k][j].
   always_comb begin
      tr = ctl.phase ? ~direction : direction;
      if (!ctl.phase) begin
         vr = tr ? ctl.k : ctl.i;
         vc = tr ? ctl.i : ctl.k;
      end else begin
         vr = tr ? ctl.j : ctl.k;
         vc = tr ? ctl.k : ctl.j;
      end
      v_ra = {vr, vc};
      m_ra = {ctl.k, ctl.j};
      p_ra = {ctl.i, ctl.k};
      p_wa = {ctl.i, ctl.j};
      m_we = ctl.load_m | ctl.wr_res;
      m_wa = ctl.load_m ? {ld_row, ld_col} : p_wa;
      m_wd = ctl.load_m ? ld_value : rnd;
   end

   mbc_ram #(.WIDTH(32), .DEPTH(64)) u_m (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   mbc_ram #(.WIDTH(32), .DEPTH(64)) u_v (
      .clock(clock), .wr_en(ctl.load_v), .wr_addr({ld_row, ld_col}),
      .wr_data(ld_value), .rd_addr(v_ra), .rd_data(v_rd));
   mbc_ram #(.WIDTH(32), .DEPTH(64)) u_p (
      .clock(clock), .wr_en(ctl.wr_pp), .wr_addr(p_wa), .wr_data(rnd),
      .rd_addr(p_ra), .rd_data(p_rd));

   logic phase_d1_ff;
   always_comb begin
      a_op = phase_d1_ff ? p_rd : v_rd;
      b_op = phase_d1_ff ? v_rd : m_rd;
      prod_in = $signed(a_op) * $signed(b_op);
      acc_in = (clr_d2_ff ? 64'd0 : acc_ff) + prod_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.mac_en && ctl.clr_acc) begin
         clr_d1_ff <= 1'b1;
      end else if (ctl.mac_en) begin
         clr_d1_ff <= 1'b0;
      end
      mac_d1_ff   <= ctl.mac_en;
      phase_d1_ff <= ctl.phase;
      mac_d2_ff   <= mac_d1_ff;
      clr_d2_ff   <= clr_d1_ff;
      prod_ff     <= prod_in;
      if (mac_d2_ff) begin
         acc_ff <= acc_in;
      end
   end

   logic        neg;
   logic [63:0] q;
   logic [64:0] s;
   always_comb begin
      neg = acc_ff[63];
      if (FRAC_BITS == 0) begin
         s = {acc_ff[63], acc_ff};
      end else begin
         q = 64'($signed(acc_ff) >>> FRAC_BITS);
         s = {q[63], q} + 65'(acc_ff[(FRAC_BITS > 0) ? FRAC_BITS - 1 : 0]);
      end
      if (FRAC_BITS == 0) q = acc_ff;
      if (!s[64] && s[63:31] != 33'd0) begin
         rnd = 32'h7FFF_FFFF;
      end else if (s[64] && s[63:31] != {33{1'b1}}) begin
         rnd = 32'h8000_0000;
      end else begin
         rnd = s[31:0];
      end
      if (neg && 1'b0) rnd = 32'd0;
   end

   assign res_value = rnd;
endmodule

// File: rtl/core/mbc_ctrl.sv
// Sequencer for the two matrix products and the result output.
// Depends on mbc_pkg.
module mbc_ctrl
   import mbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_row,
   input  logic [2:0] req_col,
   input  logic [3:0] size_in_use,
   output ctl_type    ctl,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [2:0] out_row,
   output logic [2:0] out_col,
   output logic       out_last
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAC  = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_OUT  = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, w_ff, w_in;
   logic [2:0] nm1;
   logic       acc;

   always_comb begin
      if (size_in_use == 4'd0) nm1 = 3'd0;
      else if (size_in_use > 4'd8) nm1 = 3'd7;
      else nm1 = 3'(size_in_use - 4'd1);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign acc = req_tvalid && req_tready;
   assign out_valid = (state_ff == S_OUT);
   assign out_row = i_ff;
   assign out_col = j_ff;
   assign out_last = (i_ff == nm1) && (j_ff == nm1);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; w_in = w_ff;
      ctl = '0;
      ctl.phase = phase_ff;
      ctl.i = i_ff; ctl.j = j_ff; ctl.k = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               ctl.load_m = (req_cmd == CMD_LOAD_M);
               ctl.load_v = (req_cmd == CMD_LOAD_V);
               if (req_cmd == CMD_COMPUTE) begin
                  state_in = S_MAC;
                  phase_in = 1'b0;
                  i_in = 3'd0; j_in = 3'd0; k_in = 3'd0;
               end
            end
         end
         S_MAC: begin
            ctl.mac_en = 1'b1;
            ctl.clr_acc = (k_ff == 3'd0);
            if (k_ff == nm1) begin
               state_in = S_WAIT;
               w_in = 3'd0;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_WAIT: begin
            w_in = w_ff + 3'd1;
            if (w_ff == 3'd2) begin
               if (!phase_ff) begin
                  ctl.wr_pp = 1'b1;
                  k_in = 3'd0;
                  state_in = S_MAC;
                  if (j_ff == nm1) begin
                     j_in = 3'd0;
                     if (i_ff == nm1) begin
                        i_in = 3'd0;
                        phase_in = 1'b1;
                     end else begin
                        i_in = i_ff + 3'd1;
                     end
                  end else begin
                     j_in = j_ff + 3'd1;
                  end
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_ready) begin
               ctl.wr_res = 1'b1;
               k_in = 3'd0;
               if (j_ff == nm1) begin
                  j_in = 3'd0;
                  if (i_ff == nm1) begin
                     state_in = S_IDLE;
                  end else begin
                     i_in = i_ff + 3'd1;
                     state_in = S_MAC;
                  end
               end else begin
                  j_in = j_ff + 3'd1;
                  state_in = S_MAC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; w_ff <= w_in;
   end
endmodule

// File: rtl/core/matrix_basis_change.sv
// Similarity transform V*M*V^T or V^T*M*V of an up to 8x8 Q16.16 matrix.
// Loads are taken only while idle. A compute runs 2*n^3 multiply-accumulates on one
// shared multiplier, one element at a time; no request is taken until the last
// result has been handed out.
// Each result waits in the output until taken and is written back into M.
// Depends on mbc_pkg, mbc_ctrl, mbc_datapath and mbc_ram.
module matrix_basis_change
   import mbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // cmd[1:0], row[4:2], col[7:5], value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zeros
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   logic [3:0]  size_ff;
   logic        dir_ff;
   ctl_type     ctl;
   logic [2:0]  o_row, o_col;
   logic [31:0] o_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 4'd8;
         dir_ff  <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == REG_SIZE) size_ff <= csr_wdata;
         else if (csr_index == REG_DIR) dir_ff <= csr_wdata[0];
      end
   end

   mbc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_cmd(req_tdata[1:0]),
      .req_row(req_tdata[4:2]), .req_col(req_tdata[7:5]),
      .size_in_use(size_ff), .ctl(ctl), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_row(o_row), .out_col(o_col),
      .out_last(rsp_tlast));

   mbc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .direction(dir_ff), .ctl(ctl),
      .ld_row(req_tdata[4:2]), .ld_col(req_tdata[7:5]),
      .ld_value(req_tdata[39:8]), .res_value(o_val));

   assign rsp_tdata = {2'b00, o_val, o_col, o_row};
endmodule

// File: test/matrix_basis_change_check.sv
// Checker for the matrix basis change block: watches the request, result and
// register ports, predicts every result element and compares it field by field.
// Depends on mbc_pkg.
module matrix_basis_change_check
   import mbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int          failures,
   output int          pending
);
   typedef struct packed {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        last;
   } element_type;

   element_type      expected_elements[$];
   logic signed [31:0] m_mem[64];
   logic signed [31:0] v_mem[64];
   logic signed [31:0] product_mem[64];
   logic [3:0]       size_reg;
   logic             dir_reg;

   initial failures = 0;
   assign pending = expected_elements.size();

   task automatic report(input string what, input logic [39:0] seen, input logic [39:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, seen, want);
      failures++;
   endtask

   function automatic logic [31:0] round_saturate(input longint acc);
      longint s;
      s = acc >>> 16;
      if (acc[15]) s = s + 1;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] basis_at(input int r, input int c, input bit flip);
      return flip ? v_mem[c*8+r] : v_mem[r*8+c];
   endfunction

   task automatic predict_transform();
      int n;
      longint acc;
      logic [31:0] res[64];
      n = (size_reg == 0) ? 1 : (size_reg > 8) ? 8 : size_reg;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
               acc += longint'(basis_at(i, k, dir_reg)) * longint'(m_mem[k*8+j]);
            product_mem[i*8+j] = round_saturate(acc);
         end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
               acc += longint'(product_mem[i*8+k]) * longint'(basis_at(k, j, !dir_reg));
            res[i*8+j] = round_saturate(acc);
         end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            m_mem[i*8+j] = res[i*8+j];
            expected_elements.push_back('{row: i[2:0], col: j[2:0], value: res[i*8+j],
                                          last: (i == n-1 && j == n-1)});
         end
   endtask

   always @(posedge clock) begin
      element_type want;
      if (reset) begin
         size_reg <= 4'd8;
         dir_reg  <= 1'b0;
         expected_elements.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_SIZE) size_reg <= csr_wdata;
            else if (csr_index == REG_DIR) dir_reg <= csr_wdata[0];
         end
         if (req_tvalid && req_tready) begin
            case (req_tdata[1:0])
               CMD_LOAD_M:  m_mem[req_tdata[4:2]*8+req_tdata[7:5]] = req_tdata[39:8];
               CMD_LOAD_V:  v_mem[req_tdata[4:2]*8+req_tdata[7:5]] = req_tdata[39:8];
               CMD_COMPUTE: predict_transform();
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_elements.size() == 0) begin
               report("unexpected result", rsp_tdata, 40'd0);
            end else begin
               want = expected_elements.pop_front();
               if (rsp_tdata[2:0] != want.row)
                  report("out_row", rsp_tdata[2:0], want.row);
               if (rsp_tdata[5:3] != want.col)
                  report("out_col", rsp_tdata[5:3], want.col);
               if (rsp_tdata[37:6] != want.value)
                  report("out_value", rsp_tdata[37:6], want.value);
               if (rsp_tdata[39:38] != 2'b00)
                  report("padding", rsp_tdata[39:38], 2'b00);
               if (rsp_tlast != want.last)
                  report("last", rsp_tlast, want.last);
            end
         end
      end
   end
endmodule

// File: test/matrix_basis_change_test.sv
// Testbench top for the matrix basis change block: drives loads, computes and
// register writes with random gaps and stalls, and gives the verdict.
// Depends on mbc_pkg, matrix_basis_change and matrix_basis_change_check.
module matrix_basis_change_test
   import mbc_pkg::*;
();
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [3:0]  csr_wdata;
   int          failures;
   int          pending;
   int          cycles;
   int          item_count;
   int          stall_left;
   bit          took;
   bit          calm;
   bit          m_written[64];
   bit          v_written[64];
   logic [3:0]  size_now;

   matrix_basis_change i_dut (.*);

   matrix_basis_change_check i_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
      took <= rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin
      int remaining;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else begin
         if (took) remaining = calm ? 0 : int'($urandom_range(0, 3));
         else remaining = stall_left;
         if (remaining == 0) begin
            rsp_tready <= 1'b1;
            stall_left <= 0;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= remaining - 1;
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 1 << 19) - (1 << 18);
         6: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0;
         7: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [1:0] cmd, input logic [2:0] row, input logic [2:0] col,
                       input logic [31:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, col, row, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_LOAD_M) m_written[row*8+col] = 1'b1;
      if (cmd == CMD_LOAD_V) v_written[row*8+col] = 1'b1;
      if (cmd != CMD_UNUSED) item_count++;
   endtask

   task automatic compute();
      int n;
      n = (size_now == 0) ? 1 : (size_now > 8) ? 8 : size_now;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            if (!m_written[r*8+c]) send(CMD_LOAD_M, 3'(r), 3'(c), pick_value());
            if (!v_written[r*8+c]) send(CMD_LOAD_V, 3'(r), 3'(c), pick_value());
         end
      send(CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) m_written[r*8+c] = 1'b1;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [3:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == REG_SIZE) size_now = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      item_count = 0;
      size_now = 4'd8;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: saturation at size one, identity basis, size zero, junk commands.
      write_reg(REG_SIZE, 4'd1);
      write_reg(REG_DIR, 4'd0);
      send(CMD_LOAD_M, 3'd0, 3'd0, 32'h7fff_ffff);
      send(CMD_LOAD_V, 3'd0, 3'd0, 32'h8000_0000);
      send(CMD_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
      compute();
      send(CMD_LOAD_V, 3'd0, 3'd0, 32'h7fff_ffff);
      compute();
      settle();
      write_reg(REG_SIZE, 4'd2);
      write_reg(REG_DIR, 4'd1);
      send(CMD_LOAD_M, 3'd7, 3'd7, 32'hffff_ffff);
      send(CMD_LOAD_V, 3'd7, 3'd7, 32'h0);
      send(CMD_LOAD_M, 3'd0, 3'd1, 32'h0000_8000);
      send(CMD_LOAD_M, 3'd1, 3'd0, 32'hffff_8000);
      send(CMD_LOAD_M, 3'd1, 3'd1, 32'h0003_0000);
      send(CMD_LOAD_V, 3'd0, 3'd0, 32'h0001_0000);
      send(CMD_LOAD_V, 3'd0, 3'd1, 32'h0);
      send(CMD_LOAD_V, 3'd1, 3'd0, 32'h0);
      send(CMD_LOAD_V, 3'd1, 3'd1, 32'h0001_0000);
      compute();
      compute();
      settle();
      write_reg(REG_SIZE, 4'd0);
      write_reg(2'd3, 4'hf);
      compute();
      settle();

      while (item_count < 300) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0:       size_now = 4'd0;
            1:       size_now = 4'($urandom_range(5, 8));
            2:       size_now = 4'($urandom_range(9, 15));
            default: size_now = 4'($urandom_range(1, 4));
         endcase
         write_reg(REG_SIZE, size_now);
         write_reg(REG_DIR, 4'($urandom_range(0, 1)));
         if ($urandom_range(0, 5) == 0)
            write_reg(2'(2 + $urandom_range(0, 1)), 4'($urandom));
         n = (size_now == 0) ? 1 : (size_now > 8) ? 8 : size_now;
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 2 * n)) begin
               if ($urandom_range(0, 7) == 0)
                  send($urandom_range(0, 1) ? CMD_UNUSED : 2'($urandom_range(0, 1)),
                       3'($urandom), 3'($urandom), $urandom);
               else
                  send(2'($urandom_range(0, 1)), 3'($urandom_range(0, n - 1)),
                       3'($urandom_range(0, n - 1)), pick_value());
            end
            compute();
         end
         settle();
      end

      calm = 1'b0;
      settle();
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
